@@ hw/rtl/array_doubly_linked_list_top_macros.svh @@
// Assertion helpers used by the checker
`ifndef ARRAY_DOUBLY_LINKED_LIST_TOP_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ADLL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ADLL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/adll_pkg.sv @@
package adll_pkg;

    localparam int ID_W   = 10;
    localparam int LINK_W = ID_W + 1;

    // link word: {end, id}
    typedef logic [LINK_W-1:0] t_link;
    typedef logic [ID_W-1:0]   t_id;

    localparam t_link END_LINK = t_link'(1) << ID_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    function automatic logic link_end(input t_link l);
        return l[ID_W];
    endfunction

endpackage

@@ hw/rtl/adll_link_mem.sv @@
module adll_link_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int W     = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // single port: a write cycle does not read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/array_doubly_linked_list_top.sv @@
// Doubly linked list of node ids kept in two single-port link memories (next and
// prev, NODES entries each). A request is taken when start is high and busy is low.
// Query: the anchor's links are read, then in S_EXE the successor is registered and
// shown on o_next_id with o_valid high for exactly one cycle; it cannot be held off,
// so sample it then. Insert and remove read the anchor's links, then write the link
// memories in S_EXE and S_W2; opcode 3 and out-of-range ids change nothing.
// After reset busy stays high while both memories are initialized one entry per
// cycle.
module array_doubly_linked_list_top #(
    parameter int NODES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_opcode,
    input  logic [adll_pkg::ID_W-1:0] i_anchor_id,
    input  logic [adll_pkg::ID_W-1:0] i_new_id,
    output logic                  o_valid,
    output logic [adll_pkg::ID_W-1:0] o_next_id
);

    import adll_pkg::*;

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_IDLE = 4'b0010,
        S_EXE  = 4'b0100,
        S_W2   = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [1:0]    r_op;
    t_id           r_anchor, r_new;
    logic          r_tail, n_tail;
    logic [AW-1:0] r_clr_addr;
    logic          r_out_valid, n_out_valid;
    t_id           r_out_id, n_out_id;

    logic          nx_we, pv_we;
    logic [AW-1:0] nx_addr, pv_addr;
    t_link         nx_wdata, pv_wdata;
    t_link         nx_q, pv_q;

    function automatic logic id_ok(input t_id id);
        return 32'(id) < NODES;
    endfunction

    function automatic logic link_ok(input t_link l);
        return !link_end(l) && id_ok(l[ID_W-1:0]);
    endfunction

    function automatic logic [AW-1:0] to_addr(input t_id id);
        return AW'(id);
    endfunction

    adll_link_mem #(.DEPTH(NODES), .AW(AW), .W(LINK_W)) u_next_mem (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_addr  (nx_addr),
        .i_wdata (nx_wdata),
        .o_rdata (nx_q)
    );

    adll_link_mem #(.DEPTH(NODES), .AW(AW), .W(LINK_W)) u_prev_mem (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_addr  (pv_addr),
        .i_wdata (pv_wdata),
        .o_rdata (pv_q)
    );

    logic accept;
    logic ins_ok, rem_ok;

    assign accept = start && (r_state == S_IDLE);
    assign ins_ok = (r_op == OP_INSERT) && id_ok(r_anchor) && id_ok(r_new);
    assign rem_ok = (r_op == OP_REMOVE) && id_ok(r_anchor);

    always_comb begin
        n_state     = r_state;
        n_tail      = r_tail;
        n_out_valid = 1'b0;
        n_out_id    = r_out_id;
        // idle: both memories read the anchor so data is ready in S_EXE
        nx_we    = 1'b0;
        pv_we    = 1'b0;
        nx_addr  = to_addr(i_anchor_id);
        pv_addr  = to_addr(i_anchor_id);
        nx_wdata = '0;
        pv_wdata = '0;
        case (r_state)
            S_CLR: begin
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                nx_addr  = r_clr_addr;
                pv_addr  = r_clr_addr;
                if (r_clr_addr == '0) begin
                    nx_wdata = t_link'(1);
                    pv_wdata = END_LINK;
                end else if (r_clr_addr == AW'(1)) begin
                    nx_wdata = END_LINK;
                end
                if (r_clr_addr == AW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXE;
                end
            end
            S_EXE: begin
                n_state = S_IDLE;
                if (r_op == OP_QUERY) begin
                    n_out_valid = 1'b1;
                    n_out_id    = (id_ok(r_anchor) && !link_end(nx_q)) ? nx_q[ID_W-1:0] : '0;
                end else if (ins_ok) begin
                    n_state = S_W2;
                    n_tail  = link_end(nx_q);
                    if (link_end(nx_q)) begin
                        nx_we    = 1'b1;
                        nx_addr  = to_addr(r_anchor);
                        nx_wdata = t_link'(r_new);
                        pv_we    = 1'b1;
                        pv_addr  = to_addr(r_new);
                        pv_wdata = t_link'(r_anchor);
                    end else begin
                        nx_we    = 1'b1;
                        nx_addr  = to_addr(r_new);
                        nx_wdata = nx_q;
                        pv_we    = link_ok(nx_q);
                        pv_addr  = to_addr(nx_q[ID_W-1:0]);
                        pv_wdata = t_link'(r_new);
                    end
                end else if (rem_ok) begin
                    n_state  = S_W2;
                    // unlink: predecessor skips over the anchor
                    nx_we    = link_ok(pv_q);
                    nx_addr  = to_addr(pv_q[ID_W-1:0]);
                    nx_wdata = link_end(nx_q) ? END_LINK : nx_q;
                    pv_we    = !link_end(nx_q) && link_ok(nx_q);
                    pv_addr  = to_addr(nx_q[ID_W-1:0]);
                    pv_wdata = pv_q;
                end
            end
            S_W2: begin
                n_state = S_IDLE;
                if (r_op == OP_INSERT) begin
                    if (r_tail) begin
                        nx_we    = 1'b1;
                        nx_addr  = to_addr(r_new);
                        nx_wdata = END_LINK;
                    end else begin
                        nx_we    = 1'b1;
                        nx_addr  = to_addr(r_anchor);
                        nx_wdata = t_link'(r_new);
                        pv_we    = 1'b1;
                        pv_addr  = to_addr(r_new);
                        pv_wdata = t_link'(r_anchor);
                    end
                end else begin
                    nx_we    = 1'b1;
                    nx_addr  = to_addr(r_anchor);
                    pv_we    = 1'b1;
                    pv_addr  = to_addr(r_anchor);
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_tail      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_tail      <= n_tail;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_id <= n_out_id;
        if (accept) begin
            r_op     <= i_opcode;
            r_anchor <= i_anchor_id;
            r_new    <= i_new_id;
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_next_id = r_out_id;

endmodule

@@ hw/rtl/adll_checker.sv @@
`include "array_doubly_linked_list_top_macros.svh"

module adll_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [1:0]                 i_opcode,
    input logic                       o_valid
);

    import adll_pkg::*;

    logic q_req;

    assign q_req = start && !busy && (i_opcode == OP_QUERY);

    // a query request must give a result, and every result must follow a query request
    `ADLL_ASSERT_NOW(a_query_answers, q_req, ##2 o_valid, "query request gave no result")
    `ADLL_ASSERT_NOW(a_result_has_req, o_valid, $past(q_req, 2), "result without query request")
    // any request occupies the block for at least the next cycle
    `ADLL_ASSERT_NXT(a_req_busy, start && !busy, busy, "busy not raised after request")
    `ADLL_ASSERT_NOW(a_result_idle, o_valid, !busy, "result strobe while busy")

endmodule

bind array_doubly_linked_list_top adll_checker u_adll_checker (.*);
